### hw/rtl/fee_pkg.sv
package fee_pkg;

   localparam int MAX_ROWS = 256;
   localparam int MAX_COLS = 256;

   localparam int DIM_W   = 9;
   localparam int COORD_W = 8;
   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_EFFECT = 2'd2;

   localparam logic [3:0] FX_GRAY     = 4'd0;
   localparam logic [3:0] FX_NEG_R    = 4'd1;
   localparam logic [3:0] FX_NEG_G    = 4'd2;
   localparam logic [3:0] FX_NEG_B    = 4'd3;
   localparam logic [3:0] FX_ZERO_R   = 4'd4;
   localparam logic [3:0] FX_ZERO_G   = 4'd5;
   localparam logic [3:0] FX_ZERO_B   = 4'd6;
   localparam logic [3:0] FX_CONTRAST = 4'd7;
   localparam logic [3:0] FX_HFLIP    = 4'd8;
   localparam logic [3:0] FX_VFLIP    = 4'd9;

   localparam logic [1:0] ADDR_REQ = 2'd0;
   localparam logic [1:0] ADDR_PRI = 2'd1;
   localparam logic [1:0] ADDR_PAR = 2'd2;

   localparam logic [1:0] WD_REQ   = 2'd0;
   localparam logic [1:0] WD_MAP   = 2'd1;
   localparam logic [1:0] WD_RDATA = 2'd2;
   localparam logic [1:0] WD_HOLD  = 2'd3;

   typedef struct packed {
      logic [1:0]         operation;
      logic [COORD_W-1:0] pixel_row;
      logic [COORD_W-1:0] pixel_col;
      logic [CHAN_W-1:0]  in_red;
      logic [CHAN_W-1:0]  in_green;
      logic [CHAN_W-1:0]  in_blue;
      logic [3:0]         effect_code;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic              status;
   } rsp_word_type;

   typedef struct packed {
      logic       accept;
      logic       ram_we;
      logic       ram_re;
      logic [1:0] addr_sel;
      logic [1:0] wdata_sel;
      logic       hold_load;
      logic       cnt_clear;
      logic       cnt_step;
      logic       rsp_fire;
      logic       rsp_from_ram;
      logic       rsp_status;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic       in_range;
      logic       walk_empty;
      logic       walk_swap;
      logic       walk_last;
   } ctl_stat_type;

endpackage

### hw/rtl/fee_ram.sv
module fee_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/fee_datapath.sv
module fee_datapath import fee_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  ctl_cmd_type  cmd,
   output ctl_stat_type stat,
   output rsp_word_type rsp_word,
   output logic         rsp_strobe,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata
);

   localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW    = RB + CB;
   localparam int DEPTH = 2 ** AW;
   localparam int LIM_W = 13;
   localparam logic [LIM_W-1:0] MAXR = LIM_W'(MAX_ROWS);
   localparam logic [LIM_W-1:0] MAXC = LIM_W'(MAX_COLS);
   localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);
   localparam logic             CSR_ROWS = 1'b0;
   localparam logic             CSR_COLS = 1'b1;
   localparam logic [CHAN_W-1:0] CH_MAX      = 8'd255;
   localparam logic [CHAN_W-1:0] CONTRAST_TH = 8'd127;
   localparam logic [9:0]        DIV3_MUL    = 10'd683;
   localparam int                DIV3_SHIFT  = 11;

   function automatic logic [AW-1:0] make_addr(input logic [COORD_W-1:0] row,
                                                input logic [COORD_W-1:0] col);
      logic [RB-1:0] r;
      logic [CB-1:0] c;
      r = RB'(row);
      c = CB'(col);
      return {r, c};
   endfunction

   function automatic logic [PIX_W-1:0] map_pixel(input logic [PIX_W-1:0] px,
                                                  input logic [3:0] code);
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
      logic [9:0]        sum;
      logic [19:0]       prod;
      logic [CHAN_W-1:0] m;
      logic [PIX_W-1:0]  res;
      r    = px[23:16];
      g    = px[15:8];
      b    = px[7:0];
      sum  = 10'(r) + 10'(g) + 10'(b);
      prod = 20'(sum) * 20'(DIV3_MUL);
      m    = prod[DIV3_SHIFT +: CHAN_W];
      unique case (code)
         FX_GRAY:     res = {m, m, m};
         FX_NEG_R:    res = {CH_MAX - r, g, b};
         FX_NEG_G:    res = {r, CH_MAX - g, b};
         FX_NEG_B:    res = {r, g, CH_MAX - b};
         FX_ZERO_R:   res = {8'd0, g, b};
         FX_ZERO_G:   res = {r, 8'd0, b};
         FX_ZERO_B:   res = {r, g, 8'd0};
         FX_CONTRAST: res = {(r > CONTRAST_TH) ? CH_MAX : 8'd0,
                             (g > CONTRAST_TH) ? CH_MAX : 8'd0,
                             (b > CONTRAST_TH) ? CH_MAX : 8'd0};
         default:     res = px;
      endcase
      return res;
   endfunction

   logic [DIM_W-1:0]   rows_ff, rows_in;
   logic [DIM_W-1:0]   cols_ff, cols_in;
   logic [DIM_W-1:0]   wr_dim;
   logic               cfg_we;
   logic [3:0]         code_ff, code_in;
   logic [COORD_W-1:0] i_ff, i_in;
   logic [COORD_W-1:0] j_ff, j_in;
   logic [PIX_W-1:0]   hold_ff, hold_in;
   rsp_word_type       rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;
   logic [DIM_W-1:0]   row_lim, col_lim;
   logic               col_last, row_last;
   logic [DIM_W-1:0]   flip_row, flip_col;
   logic [COORD_W-1:0] par_row, par_col;
   logic [AW-1:0]      addr;
   logic [PIX_W-1:0]   wdata;
   logic [PIX_W-1:0]   rdata;
   logic [3:0]         req_code;

   // configuration
   assign wr_dim = pwdata[DIM_W-1:0];
   assign cfg_we = psel & penable & pwrite;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (cfg_we && paddr[2] == CSR_ROWS) begin
         if (wr_dim == '0) begin
            rows_in = DIM_ONE;
         end else if (LIM_W'(wr_dim) > MAXR) begin
            rows_in = MAXR[DIM_W-1:0];
         end else begin
            rows_in = wr_dim;
         end
      end
      if (cfg_we && paddr[2] == CSR_COLS) begin
         if (wr_dim == '0) begin
            cols_in = DIM_ONE;
         end else if (LIM_W'(wr_dim) > MAXC) begin
            cols_in = MAXC[DIM_W-1:0];
         end else begin
            cols_in = wr_dim;
         end
      end
   end

   assign prdata = (paddr[2] == CSR_COLS) ? 32'(cols_ff) : 32'(rows_ff);

   // walk bounds and partner coordinates
   assign row_lim  = (code_ff == FX_VFLIP) ? (rows_ff >> 1) : rows_ff;
   assign col_lim  = (code_ff == FX_HFLIP) ? (cols_ff >> 1) : cols_ff;
   assign col_last = (DIM_W'(j_ff) == col_lim - DIM_ONE);
   assign row_last = (DIM_W'(i_ff) == row_lim - DIM_ONE);
   assign flip_row = rows_ff - DIM_ONE - DIM_W'(i_ff);
   assign flip_col = cols_ff - DIM_ONE - DIM_W'(j_ff);
   assign par_row  = (code_ff == FX_VFLIP) ? flip_row[COORD_W-1:0] : i_ff;
   assign par_col  = (code_ff == FX_HFLIP) ? flip_col[COORD_W-1:0] : j_ff;

   // status
   assign req_code        = req_word.effect_code;
   assign stat.req_op     = req_word.operation;
   assign stat.in_range   = (DIM_W'(req_word.pixel_row) < rows_ff) &&
                            (DIM_W'(req_word.pixel_col) < cols_ff);
   assign stat.walk_swap  = (req_code == FX_HFLIP) || (req_code == FX_VFLIP);
   assign stat.walk_empty = (req_code > FX_VFLIP) ||
                            ((req_code == FX_HFLIP) && (cols_ff < DIM_W'(2))) ||
                            ((req_code == FX_VFLIP) && (rows_ff < DIM_W'(2)));
   assign stat.walk_last  = col_last && row_last;

   // frame store access
   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_PRI: addr = make_addr(i_ff, j_ff);
         ADDR_PAR: addr = make_addr(par_row, par_col);
         default:  addr = make_addr(req_word.pixel_row, req_word.pixel_col);
      endcase
      unique case (cmd.wdata_sel)
         WD_REQ:   wdata = {req_word.in_red, req_word.in_green, req_word.in_blue};
         WD_MAP:   wdata = map_pixel(rdata, code_ff);
         WD_RDATA: wdata = rdata;
         WD_HOLD:  wdata = hold_ff;
      endcase
   end

   fee_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame (
      .clock (clock),
      .we    (cmd.ram_we),
      .waddr (addr),
      .wdata (wdata),
      .re    (cmd.ram_re),
      .raddr (addr),
      .rdata (rdata)
   );

   // counters, hold and response
   always_comb begin
      code_in = cmd.accept ? req_code : code_ff;
      hold_in = cmd.hold_load ? rdata : hold_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      if (cmd.cnt_clear) begin
         i_in = '0;
         j_in = '0;
      end else if (cmd.cnt_step) begin
         if (col_last) begin
            j_in = '0;
            i_in = i_ff + COORD_W'(1);
         end else begin
            j_in = j_ff + COORD_W'(1);
         end
      end
      rsp_in    = rsp_ff;
      strobe_in = cmd.rsp_fire;
      if (cmd.rsp_fire) begin
         if (cmd.rsp_from_ram) begin
            rsp_in = {rdata, 1'b0};
         end else begin
            rsp_in = '0;
            rsp_in.status = cmd.rsp_status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= DIM_ONE;
         cols_ff   <= DIM_ONE;
         strobe_ff <= 1'b0;
      end else begin
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         strobe_ff <= strobe_in;
      end
      code_ff <= code_in;
      hold_ff <= hold_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_word   = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

### hw/rtl/fee_ctrl.sv
module fee_ctrl import fee_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd,
   output logic         busy
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_RD_WAIT = 3'd1;
   localparam logic [2:0] ST_MAP_RD  = 3'd2;
   localparam logic [2:0] ST_MAP_WR  = 3'd3;
   localparam logic [2:0] ST_SW_RDA  = 3'd4;
   localparam logic [2:0] ST_SW_RDB  = 3'd5;
   localparam logic [2:0] ST_SW_WRA  = 3'd6;
   localparam logic [2:0] ST_SW_WRB  = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               unique case (stat.req_op)
                  OP_WRITE: begin
                     cmd.ram_we     = stat.in_range;
                     cmd.addr_sel   = ADDR_REQ;
                     cmd.wdata_sel  = WD_REQ;
                     cmd.rsp_fire   = 1'b1;
                     cmd.rsp_status = !stat.in_range;
                  end
                  OP_READ: begin
                     if (stat.in_range) begin
                        cmd.ram_re = 1'b1;
                        cmd.addr_sel = ADDR_REQ;
                        state_in = ST_RD_WAIT;
                     end else begin
                        cmd.rsp_fire   = 1'b1;
                        cmd.rsp_status = 1'b1;
                     end
                  end
                  OP_EFFECT: begin
                     if (stat.walk_empty) begin
                        cmd.rsp_fire = 1'b1;
                     end else begin
                        cmd.cnt_clear = 1'b1;
                        state_in = stat.walk_swap ? ST_SW_RDA : ST_MAP_RD;
                     end
                  end
                  default: begin
                     cmd.rsp_fire = 1'b1;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            cmd.rsp_fire     = 1'b1;
            cmd.rsp_from_ram = 1'b1;
            state_in = ST_IDLE;
         end
         ST_MAP_RD: begin
            cmd.ram_re   = 1'b1;
            cmd.addr_sel = ADDR_PRI;
            state_in = ST_MAP_WR;
         end
         ST_MAP_WR: begin
            cmd.ram_we    = 1'b1;
            cmd.addr_sel  = ADDR_PRI;
            cmd.wdata_sel = WD_MAP;
            cmd.cnt_step  = 1'b1;
            cmd.rsp_fire  = stat.walk_last;
            state_in = stat.walk_last ? ST_IDLE : ST_MAP_RD;
         end
         ST_SW_RDA: begin
            cmd.ram_re   = 1'b1;
            cmd.addr_sel = ADDR_PRI;
            state_in = ST_SW_RDB;
         end
         ST_SW_RDB: begin
            cmd.ram_re    = 1'b1;
            cmd.addr_sel  = ADDR_PAR;
            cmd.hold_load = 1'b1;
            state_in = ST_SW_WRA;
         end
         ST_SW_WRA: begin
            cmd.ram_we    = 1'b1;
            cmd.addr_sel  = ADDR_PRI;
            cmd.wdata_sel = WD_RDATA;
            state_in = ST_SW_WRB;
         end
         ST_SW_WRB: begin
            cmd.ram_we    = 1'b1;
            cmd.addr_sel  = ADDR_PAR;
            cmd.wdata_sel = WD_HOLD;
            cmd.cnt_step  = 1'b1;
            cmd.rsp_fire  = stat.walk_last;
            state_in = stat.walk_last ? ST_IDLE : ST_SW_RDA;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### hw/rtl/frame_effect_engine_top.sv
// channel  | handshake                         | payload
// request  | start, busy (taken: start & !busy)| req_word
// response | rsp_strobe (one cycle, no stall)  | rsp_word
// csr      | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// pixel write, out-of-range access, unknown op or code, 1-wide flip: answered at accept
// pixel read: one registered read of the frame ram, then the response
// point effect: an accept state, then per pixel in use a read, then a write
// flip: an accept state, then per swapped pixel pair two reads, then two writes
// response appears the cycle after the item finishes; synchronous reset,
// frame ram holds no reset; the receiver cannot stall
module frame_effect_engine_top import fee_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output rsp_word_type rsp_word,
   output logic         rsp_strobe,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   assign pready = 1'b1;

   fee_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   fee_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_word   (rsp_word),
      .rsp_strobe (rsp_strobe),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata)
   );

   a_write_responds: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.operation == OP_WRITE) |=> (rsp_strobe && !busy))
      else $error("pixel write did not respond in the next cycle");

   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.operation == OP_READ && stat.in_range)
      |=> (busy && !rsp_strobe) ##1 rsp_strobe)
      else $error("pixel read did not respond after two cycles");

   a_ram_one_op: assert property (@(posedge clock) disable iff (reset)
      cmd.ram_we |-> !cmd.ram_re)
      else $error("frame ram read and write in the same cycle");

   a_walk_ends_on_last: assert property (@(posedge clock) disable iff (reset)
      (busy && cmd.rsp_fire && !cmd.rsp_from_ram) |-> (stat.walk_last && cmd.cnt_step))
      else $error("effect walk finished before its last pixel");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import fee_pkg::*;

   localparam int FRAME_DIM = 256;
   localparam int RANDOM_TARGET = 870;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [3:0] FX_NONE_CODE = 4'd12;
   localparam logic [3:0] FX_LAST_CODE = 4'd15;
   localparam logic [2:0] CSR_ROWS = 3'd0;
   localparam logic [2:0] CSR_COLS = 3'd4;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   rsp_word_type rsp_word;
   logic         rsp_strobe;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [2:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   frame_effect_engine_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_word(rsp_word), .rsp_strobe(rsp_strobe),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   // shadow frame and settings
   logic [PIX_W-1:0] frame_copy [0:FRAME_DIM*FRAME_DIM-1];
   bit               pixel_written [0:FRAME_DIM*FRAME_DIM-1];
   int               img_rows = 1;
   int               img_cols = 1;

   rsp_word_type pending_rsp [$];
   int fail_count = 0;
   int gap_max = 6;
   int items_sent = 0;
   int n_writes = 0, n_reads = 0, n_effects = 0, n_out_range = 0, n_unused = 0;
   int n_settings = 0;

   function automatic logic [PIX_W-1:0] remap_pixel(logic [PIX_W-1:0] px, logic [3:0] code);
      logic [CHAN_W-1:0] r, g, b, m;
      r = px[23:16];
      g = px[15:8];
      b = px[7:0];
      m = CHAN_W'((int'(r) + int'(g) + int'(b)) / 3);
      case (code)
         FX_GRAY:     return {m, m, m};
         FX_NEG_R:    return {~r, g, b};
         FX_NEG_G:    return {r, ~g, b};
         FX_NEG_B:    return {r, g, ~b};
         FX_ZERO_R:   return {8'h00, g, b};
         FX_ZERO_G:   return {r, 8'h00, b};
         FX_ZERO_B:   return {r, g, 8'h00};
         FX_CONTRAST: return {(r > 8'd127) ? 8'hff : 8'h00, (g > 8'd127) ? 8'hff : 8'h00,
                              (b > 8'd127) ? 8'hff : 8'h00};
         default:     return px;
      endcase
   endfunction

   function automatic void swap_entries(int a, int b);
      logic [PIX_W-1:0] px;
      bit               ok;
      px = frame_copy[a];
      frame_copy[a] = frame_copy[b];
      frame_copy[b] = px;
      ok = pixel_written[a];
      pixel_written[a] = pixel_written[b];
      pixel_written[b] = ok;
   endfunction

   function automatic void run_frame_effect(logic [3:0] code);
      if (code <= FX_CONTRAST) begin
         for (int i = 0; i < img_rows; i++)
            for (int j = 0; j < img_cols; j++)
               frame_copy[i*FRAME_DIM+j] = remap_pixel(frame_copy[i*FRAME_DIM+j], code);
      end else if (code == FX_HFLIP) begin
         for (int i = 0; i < img_rows; i++)
            for (int j = 0; j < img_cols / 2; j++)
               swap_entries(i*FRAME_DIM+j, i*FRAME_DIM+(img_cols-1-j));
      end else if (code == FX_VFLIP) begin
         for (int i = 0; i < img_rows / 2; i++)
            for (int j = 0; j < img_cols; j++)
               swap_entries(i*FRAME_DIM+j, (img_rows-1-i)*FRAME_DIM+j);
      end
   endfunction

   function automatic rsp_word_type predict_word(req_word_type w);
      rsp_word_type res;
      bit           in_range;
      int           idx;
      res = '0;
      in_range = (int'(w.pixel_row) < img_rows) && (int'(w.pixel_col) < img_cols);
      idx = int'(w.pixel_row) * FRAME_DIM + int'(w.pixel_col);
      if (w.operation == OP_WRITE || w.operation == OP_READ) begin
         if (!in_range) begin
            res.status = 1'b1;
            n_out_range++;
         end else if (w.operation == OP_WRITE) begin
            frame_copy[idx] = {w.in_red, w.in_green, w.in_blue};
            pixel_written[idx] = 1'b1;
            n_writes++;
         end else begin
            {res.out_red, res.out_green, res.out_blue} = frame_copy[idx];
            n_reads++;
         end
      end else if (w.operation == OP_EFFECT) begin
         run_frame_effect(w.effect_code);
         n_effects++;
      end else begin
         n_unused++;
      end
      return res;
   endfunction

   function automatic int clamp_dim(logic [31:0] raw);
      int v;
      v = int'(raw[DIM_W-1:0]);
      if (v == 0) return 1;
      if (v > FRAME_DIM) return FRAME_DIM;
      return v;
   endfunction

   function automatic req_word_type make_word(logic [1:0] op, int row, int col,
                                              int red, int green, int blue, logic [3:0] code);
      req_word_type w;
      w.operation = op;
      w.pixel_row = COORD_W'(row);
      w.pixel_col = COORD_W'(col);
      w.in_red = CHAN_W'(red);
      w.in_green = CHAN_W'(green);
      w.in_blue = CHAN_W'(blue);
      w.effect_code = code;
      return w;
   endfunction

   function automatic bit pick_written(output int row, output int col);
      for (int t = 0; t < 24; t++) begin
         row = $urandom_range(0, img_rows - 1);
         col = $urandom_range(0, img_cols - 1);
         if (pixel_written[row*FRAME_DIM+col]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int sel, row, col;
      w.operation = OP_WRITE;
      w.pixel_row = COORD_W'($urandom);
      w.pixel_col = COORD_W'($urandom);
      w.in_red = CHAN_W'($urandom);
      w.in_green = CHAN_W'($urandom);
      w.in_blue = CHAN_W'($urandom);
      w.effect_code = 4'($urandom);
      sel = $urandom_range(0, 99);
      if (sel >= 36 && sel < 68 && pick_written(row, col)) begin
         w.operation = OP_READ;
         w.pixel_row = COORD_W'(row);
         w.pixel_col = COORD_W'(col);
      end else if (sel >= 68 && sel < 80) begin
         w.operation = OP_EFFECT;
         w.effect_code = 4'($urandom_range(FX_GRAY, FX_VFLIP));
      end else if (sel >= 80 && sel < 84) begin
         w.operation = OP_EFFECT;
         w.effect_code = 4'($urandom_range(FX_GRAY, FX_LAST_CODE));
      end else if (sel >= 84 && sel < 94 && (img_rows < FRAME_DIM || img_cols < FRAME_DIM)) begin
         w.operation = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
         if (img_rows < FRAME_DIM && (img_cols == FRAME_DIM || $urandom_range(0, 1)))
            w.pixel_row = COORD_W'($urandom_range(img_rows, FRAME_DIM - 1));
         else
            w.pixel_col = COORD_W'($urandom_range(img_cols, FRAME_DIM - 1));
      end else if (sel >= 94) begin
         w.operation = OP_UNUSED;
      end else begin
         w.pixel_row = COORD_W'($urandom_range(0, img_rows - 1));
         w.pixel_col = COORD_W'($urandom_range(0, img_cols - 1));
      end
      return w;
   endfunction

   function automatic void note_mismatch(string what, rsp_word_type want, rsp_word_type got);
      if (fail_count < 10)
         $display("mismatch %s at %0t: expected r=%0d g=%0d b=%0d st=%0d, got r=%0d g=%0d b=%0d st=%0d",
                  what, $time, want.out_red, want.out_green, want.out_blue, want.status,
                  got.out_red, got.out_green, got.out_blue, got.status);
      fail_count++;
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            note_mismatch("unexpected word", '0, rsp_word);
         end else begin
            want = pending_rsp.pop_front();
            if (want.out_red !== rsp_word.out_red || want.out_green !== rsp_word.out_green ||
                want.out_blue !== rsp_word.out_blue || want.status !== rsp_word.status)
               note_mismatch("in response", want, rsp_word);
         end
      end
   end

   // all tasks start and end on a falling edge
   task automatic send_word(req_word_type w);
      int           gap;
      rsp_word_type next_rsp;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_word = w;
      do @(posedge clock); while (busy);
      next_rsp = predict_word(w);
      pending_rsp = {pending_rsp, next_rsp};
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (pending_rsp.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      wait_drained();
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == CSR_ROWS) img_rows = clamp_dim(data);
      else if (addr == CSR_COLS) img_cols = clamp_dim(data);
      n_settings++;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic test_directed();
      gap_max = 6;
      send_word(make_word(OP_WRITE, 0, 0, 255, 0, 128, FX_GRAY));
      send_word(make_word(OP_READ, 0, 0, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_WRITE, 1, 0, 1, 2, 3, FX_GRAY));
      send_word(make_word(OP_READ, 0, 255, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_UNUSED, 255, 255, 255, 255, 255, FX_LAST_CODE));
      csr_write(CSR_ROWS, 32'd2);
      csr_write(CSR_COLS, 32'd3);
      send_word(make_word(OP_WRITE, 0, 0, 255, 0, 127, FX_GRAY));
      send_word(make_word(OP_WRITE, 0, 1, 128, 255, 0, FX_GRAY));
      send_word(make_word(OP_WRITE, 0, 2, 1, 2, 3, FX_GRAY));
      send_word(make_word(OP_WRITE, 1, 0, 127, 128, 255, FX_GRAY));
      send_word(make_word(OP_WRITE, 1, 1, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_WRITE, 1, 2, 255, 255, 255, FX_GRAY));
      send_word(make_word(OP_EFFECT, 0, 0, 0, 0, 0, FX_HFLIP));
      send_word(make_word(OP_READ, 0, 0, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_EFFECT, 0, 0, 0, 0, 0, FX_VFLIP));
      send_word(make_word(OP_READ, 1, 2, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_EFFECT, 0, 0, 0, 0, 0, FX_CONTRAST));
      send_word(make_word(OP_READ, 0, 1, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_EFFECT, 0, 0, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_READ, 1, 1, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_EFFECT, 0, 0, 0, 0, 0, FX_NEG_G));
      send_word(make_word(OP_EFFECT, 0, 0, 0, 0, 0, FX_ZERO_B));
      send_word(make_word(OP_EFFECT, 0, 0, 0, 0, 0, FX_NONE_CODE));
      send_word(make_word(OP_READ, 0, 2, 0, 0, 0, FX_GRAY));
   endtask

   task automatic test_register_clamp();
      csr_write(CSR_ROWS, 32'd0);
      csr_write(CSR_COLS, 32'h0000_0600);
      send_word(make_word(OP_WRITE, 0, 0, 10, 20, 30, FX_GRAY));
      send_word(make_word(OP_READ, 0, 0, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_READ, 1, 0, 0, 0, 0, FX_GRAY));
      csr_write(CSR_ROWS, 32'd300);
      csr_write(CSR_COLS, 32'h0000_0203);
      send_word(make_word(OP_WRITE, 255, 0, 200, 100, 50, FX_GRAY));
      send_word(make_word(OP_WRITE, 0, 2, 5, 250, 125, FX_GRAY));
      send_word(make_word(OP_WRITE, 0, 3, 1, 1, 1, FX_GRAY));
      send_word(make_word(OP_EFFECT, 0, 0, 0, 0, 0, FX_VFLIP));
      send_word(make_word(OP_READ, 0, 0, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_READ, 255, 2, 0, 0, 0, FX_GRAY));
      csr_write(CSR_ROWS, 32'd511);
      csr_write(CSR_COLS, 32'd1);
      send_word(make_word(OP_READ, 255, 0, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_READ, 128, 1, 0, 0, 0, FX_GRAY));
   endtask

   task automatic test_random_mix();
      int rows, cols;
      logic [31:0] raw;
      while (items_sent < RANDOM_TARGET) begin
         rows = ($urandom_range(0, 9) == 0) ? FRAME_DIM : $urandom_range(1, 16);
         cols = ($urandom_range(0, 9) == 0 && rows <= 16) ? FRAME_DIM : $urandom_range(1, 16);
         if (rows == FRAME_DIM) cols = $urandom_range(1, 4);
         if (cols == FRAME_DIM) rows = $urandom_range(1, 4);
         raw = 32'(rows);
         if (rows == 1 && $urandom_range(0, 1)) raw = 32'd0;
         if (rows == FRAME_DIM && $urandom_range(0, 1)) raw = 32'($urandom_range(257, 511));
         csr_write(CSR_ROWS, raw);
         raw = 32'(cols) | ($urandom_range(0, 3) == 0 ? 32'h0001_0000 : 32'd0);
         csr_write(CSR_COLS, raw);
         gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
         repeat ($urandom_range(30, 70)) begin
            if ($urandom_range(0, 39) == 0) wait_drained();
            send_word(random_word());
         end
      end
   endtask

   task automatic test_full_frame();
      int row, col;
      gap_max = 6;
      csr_write(CSR_ROWS, 32'd256);
      csr_write(CSR_COLS, 32'd256);
      send_word(make_word(OP_WRITE, 0, 0, $urandom, $urandom, $urandom, FX_GRAY));
      send_word(make_word(OP_WRITE, 0, 255, $urandom, $urandom, $urandom, FX_GRAY));
      send_word(make_word(OP_WRITE, 255, 0, $urandom, $urandom, $urandom, FX_GRAY));
      send_word(make_word(OP_WRITE, 255, 255, $urandom, $urandom, $urandom, FX_GRAY));
      repeat (12) begin
         row = $urandom_range(0, FRAME_DIM - 1);
         col = $urandom_range(0, FRAME_DIM - 1);
         send_word(make_word(OP_WRITE, row, col, $urandom, $urandom, $urandom, FX_GRAY));
      end
      send_word(make_word(OP_READ, 255, 255, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_EFFECT, 0, 0, 0, 0, 0, FX_HFLIP));
      send_word(make_word(OP_READ, 0, 255, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_READ, 255, 0, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_EFFECT, 0, 0, 0, 0, 0, FX_VFLIP));
      send_word(make_word(OP_READ, 255, 255, 0, 0, 0, FX_GRAY));
      send_word(make_word(OP_READ, 0, 0, 0, 0, 0, FX_GRAY));
      // last random pixel after both flips
      send_word(make_word(OP_READ, FRAME_DIM - 1 - row, FRAME_DIM - 1 - col, 0, 0, 0,
                          FX_GRAY));
   endtask

   initial begin
      int guard;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_register_clamp();
      test_random_mix();
      test_full_frame();
      start = 1'b0;
      guard = 0;
      while (pending_rsp.size() != 0 && guard < 400000) begin
         @(negedge clock);
         guard++;
      end
      repeat (20) @(negedge clock);
      if (pending_rsp.size() != 0) begin
         $display("%0d responses never arrived", pending_rsp.size());
         fail_count += pending_rsp.size();
      end
      $display("sent %0d words: %0d pixel writes, %0d pixel reads, %0d frame effects",
               items_sent, n_writes, n_reads, n_effects);
      $display("%0d out-of-range accesses, %0d unused ops, %0d register writes, %0d mismatches",
               n_out_range, n_unused, n_settings, fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
